// ===== design/ipf_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and constants for the integer printf formatter
// no dependencies; imported by integer_printf_formatter

package ipf_pkg;

    // defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int VALUE_BITS_DEF = 64;

    // input beat layout
    localparam int IN_DATA_W   = 80;
    localparam int IN_USER_W   = 5;
    localparam int IN_LEFT_BIT = 64;
    localparam int IN_PLUS_BIT = 65;
    localparam int IN_SPACE_BIT = 66;
    localparam int IN_ALT_BIT  = 67;
    localparam int IN_ZERO_BIT = 68;
    localparam int IN_WIDTH_LSB = 69;
    localparam int IN_OSZ_LSB  = 3;

    // conversion kinds
    localparam logic [2:0] CMD_D   = 3'd0;
    localparam logic [2:0] CMD_U   = 3'd1;
    localparam logic [2:0] CMD_O   = 3'd2;
    localparam logic [2:0] CMD_X   = 3'd3;
    localparam logic [2:0] CMD_XU  = 3'd4;
    localparam logic [2:0] CMD_P   = 3'd5;
    localparam logic [2:0] CMD_C   = 3'd6;
    localparam logic [2:0] CMD_PCT = 3'd7;

    // operand sizes
    localparam logic [1:0] OSZ_INT   = 2'd0;
    localparam logic [1:0] OSZ_SHORT = 2'd1;

    localparam int SHORT_BITS = 16;
    localparam int INT_BITS   = 32;

    // ascii
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_UPPER_X = 8'h58;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_LEN,
        ST_PLAN,
        ST_EMIT
    } state_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] alpha;
        alpha = upper ? CH_UPPER_A : CH_LOWER_A;
        if (d < 4'd10)
        begin
            return CH_ZERO + {4'b0000, d};
        end
        return alpha + {4'b0000, d} - 8'd10;
    endfunction

endpackage

// ===== design/integer_printf_formatter.sv =====
`timescale 1ns / 1ps
// integer printf formatter: one conversion request in, one ascii character per output beat
// depends on ipf_pkg

// Usage
// Input channel s_*: one beat is one request. s_tuser carries the conversion kind and the
// operand size, s_tdata the value, the flags and the field width. s_tready is high only
// while the block is idle; a request is taken, worked on, and fully sent before the next.
// Output channel m_*: one beat per character of the formatted field, m_tlast on the final
// character. Every request yields at least one character.
// Flow: decimal kinds (d, u) run a bit-serial binary-to-bcd converter, one value bit per
// cycle, in the CONV state. All other kinds load their digits directly on acceptance. Then
// the LEN state finds the digit count and the PLAN state lays out the field, after which
// characters leave one per cycle while m_tready allows, max(field width, sign/prefix +
// digits) of them, at most 64 by default.
// The block is ready again once the last character sits in the output register.
// Stalls: m_tready low holds the current output beat and pauses the character stream.
// Reset: asynchronous, returns to idle and drops m_tvalid; no clearing pass is needed.

module integer_printf_formatter
    import ipf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // value[63:0], left_justify, force_plus, space_sign, alt_form, zero_pad,
    // field_width[6:0], zero fill
    input  logic [IN_DATA_W-1:0] s_tdata,
    // cmd[2:0], operand_size[1:0]
    input  logic [IN_USER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_char[7:0]
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);

    localparam int DIG_N    = (VALUE_BITS + 2) / 3;
    localparam int DI_W     = $clog2(DIG_N);
    localparam int DL_W     = $clog2(DIG_N + 1);
    localparam int BC_W     = $clog2(VALUE_BITS);
    localparam int INT_EFF  = (VALUE_BITS < INT_BITS) ? VALUE_BITS : INT_BITS;
    // character position counter, covers a saturated width and the longest field
    localparam int CNT_W    = $clog2(MAX_WIDTH + DIG_N + 3);

    // request fields
    logic [2:0]            in_cmd;
    logic [1:0]            in_osz;
    logic [VALUE_BITS-1:0] value_vb;
    logic                  in_left;
    logic                  in_plus;
    logic                  in_space;
    logic                  in_alt;
    logic                  in_zero;
    logic [6:0]            in_width;

    assign in_cmd   = s_tuser[2:0];
    assign in_osz   = s_tuser[IN_OSZ_LSB +: 2];
    assign value_vb = s_tdata[VALUE_BITS-1:0];
    assign in_left  = s_tdata[IN_LEFT_BIT];
    assign in_plus  = s_tdata[IN_PLUS_BIT];
    assign in_space = s_tdata[IN_SPACE_BIT];
    assign in_alt   = s_tdata[IN_ALT_BIT];
    assign in_zero  = s_tdata[IN_ZERO_BIT];
    assign in_width = s_tdata[IN_WIDTH_LSB +: 7];

    // registers
    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [3:0]            dig_reg [DIG_N];
    logic [3:0]            dig_next [DIG_N];
    logic [BC_W-1:0]       cnt_reg, cnt_next;
    logic                  upper_reg, upper_next;
    logic                  use_lit_reg, use_lit_next;
    logic [7:0]            lit_reg, lit_next;
    logic [1:0]            pre_len_reg, pre_len_next;
    logic [7:0]            pre0_reg, pre0_next;
    logic [7:0]            pre1_reg, pre1_next;
    logic                  left_reg, left_next;
    logic                  zero_reg, zero_next;
    logic [CNT_W-1:0]      width_reg, width_next;
    logic [CNT_W-1:0]      dig_len_reg, dig_len_next;
    logic [CNT_W-1:0]      b1_reg, b1_next;
    logic [CNT_W-1:0]      b2_reg, b2_next;
    logic [CNT_W-1:0]      b3_reg, b3_next;
    logic [CNT_W-1:0]      b4_reg, b4_next;
    logic [CNT_W-1:0]      last_pos_reg, last_pos_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;

    // control
    logic accept;
    logic emit_go;
    logic is_dec;
    logic conv_done;
    logic emit_last;

    // load path
    logic [VALUE_BITS-1:0] mask;
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] src;
    logic [DIG_N*4-1:0]    src_pad;
    logic                  sign_bit;
    logic                  is_neg;
    logic                  v_nz;
    logic [8:0]            width_ext;
    logic [CNT_W-1:0]      width_sat;
    logic [1:0]            ld_pre_len;
    logic [7:0]            ld_pre0;
    logic [7:0]            ld_pre1;
    logic                  ld_use_lit;
    logic [7:0]            ld_lit;

    // conversion, layout and emit paths
    logic [3:0]            adj [DIG_N];
    logic [DL_W-1:0]       nz_len;
    logic [CNT_W-1:0]      total;
    logic [CNT_W-1:0]      pad;
    logic [CNT_W-1:0]      lead_sp;
    logic [CNT_W-1:0]      lead_zero;
    logic [CNT_W-1:0]      plan_b1;
    logic [CNT_W-1:0]      plan_b2;
    logic [CNT_W-1:0]      plan_b3;
    logic [CNT_W-1:0]      dpos;
    logic [DI_W-1:0]       didx;
    logic [7:0]            emit_char;

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = is_dec ? ST_CONV : ST_LEN;
                end
            end
            ST_CONV:
            begin
                if (conv_done)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                state_next = ST_PLAN;
            end
            ST_PLAN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_go && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- fsm outputs
    always_comb
    begin
        s_tready = 1'b0;
        emit_go  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_EMIT:
            begin
                emit_go = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept    = s_tvalid && s_tready;
    assign is_dec    = (in_cmd == CMD_D) || (in_cmd == CMD_U);
    assign conv_done = (cnt_reg == BC_W'(VALUE_BITS - 1));
    assign emit_last = (pos_reg == last_pos_reg);

    // ---------------------------------------------------------------- request decode
    always_comb
    begin
        case (in_osz)
            OSZ_SHORT: mask = {VALUE_BITS{1'b1}} >> (VALUE_BITS - SHORT_BITS);
            OSZ_INT:   mask = {VALUE_BITS{1'b1}} >> (VALUE_BITS - INT_EFF);
            default:   mask = {VALUE_BITS{1'b1}};
        endcase
    end

    assign v = value_vb & mask;

    always_comb
    begin
        case (in_osz)
            OSZ_SHORT: sign_bit = v[SHORT_BITS-1];
            OSZ_INT:   sign_bit = v[INT_EFF-1];
            default:   sign_bit = v[VALUE_BITS-1];
        endcase
    end

    assign is_neg  = (in_cmd == CMD_D) && sign_bit;
    assign mag     = is_neg ? ((~v + VALUE_BITS'(1)) & mask) : v;
    assign src     = (in_cmd == CMD_P) ? value_vb : mag;
    assign src_pad = (DIG_N*4)'(src);
    assign v_nz    = (v != '0);

    assign width_ext = {2'b00, in_width};
    assign width_sat = (width_ext > 9'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : CNT_W'(in_width);

    always_comb
    begin
        ld_pre_len = 2'd0;
        ld_pre0    = CH_ZERO;
        ld_pre1    = CH_LOWER_X;
        ld_use_lit = 1'b0;
        ld_lit     = CH_PERCENT;
        unique case (in_cmd)
            CMD_D:
            begin
                if (is_neg)
                begin
                    ld_pre_len = 2'd1;
                    ld_pre0    = CH_MINUS;
                end
                else if (in_plus)
                begin
                    ld_pre_len = 2'd1;
                    ld_pre0    = CH_PLUS;
                end
                else if (in_space)
                begin
                    ld_pre_len = 2'd1;
                    ld_pre0    = CH_SPACE;
                end
            end
            CMD_O:
            begin
                if (in_alt && v_nz)
                begin
                    ld_pre_len = 2'd1;
                end
            end
            CMD_X, CMD_XU:
            begin
                if (in_alt && v_nz)
                begin
                    ld_pre_len = 2'd2;
                end
                ld_pre1 = (in_cmd == CMD_XU) ? CH_UPPER_X : CH_LOWER_X;
            end
            CMD_P:
            begin
                ld_pre_len = 2'd2;
            end
            CMD_C:
            begin
                ld_use_lit = 1'b1;
                ld_lit     = value_vb[7:0];
            end
            CMD_PCT:
            begin
                ld_use_lit = 1'b1;
            end
            default:
            begin
                ld_pre_len = 2'd0;
            end
        endcase
    end

    // ---------------------------------------------------------------- digit count
    always_comb
    begin
        nz_len = DL_W'(1);
        for (int i = 0; i < DIG_N; i++)
        begin
            if (dig_reg[i] != 4'd0)
            begin
                nz_len = DL_W'(i + 1);
            end
        end
    end

    // ---------------------------------------------------------------- field layout
    assign total     = CNT_W'(pre_len_reg) + dig_len_reg;
    assign pad       = (width_reg > total) ? (width_reg - total) : '0;
    assign lead_sp   = (!left_reg && !zero_reg) ? pad : '0;
    assign lead_zero = (!left_reg && zero_reg) ? pad : '0;
    assign plan_b1   = lead_sp;
    assign plan_b2   = plan_b1 + CNT_W'(pre_len_reg);
    assign plan_b3   = plan_b2 + lead_zero;

    // ---------------------------------------------------------------- character select
    assign dpos = b4_reg - CNT_W'(1) - pos_reg;
    assign didx = dpos[DI_W-1:0];

    always_comb
    begin
        if (pos_reg < b1_reg)
        begin
            emit_char = CH_SPACE;
        end
        else if (pos_reg < b2_reg)
        begin
            emit_char = (pos_reg == b1_reg) ? pre0_reg : pre1_reg;
        end
        else if (pos_reg < b3_reg)
        begin
            emit_char = CH_ZERO;
        end
        else if (pos_reg < b4_reg)
        begin
            emit_char = use_lit_reg ? lit_reg : digit_char(dig_reg[didx], upper_reg);
        end
        else
        begin
            emit_char = CH_SPACE;
        end
    end

    // ---------------------------------------------------------------- datapath
    always_comb
    begin
        mag_next      = mag_reg;
        cnt_next      = cnt_reg;
        upper_next    = upper_reg;
        use_lit_next  = use_lit_reg;
        lit_next      = lit_reg;
        pre_len_next  = pre_len_reg;
        pre0_next     = pre0_reg;
        pre1_next     = pre1_reg;
        left_next     = left_reg;
        zero_next     = zero_reg;
        width_next    = width_reg;
        dig_len_next  = dig_len_reg;
        b1_next       = b1_reg;
        b2_next       = b2_reg;
        b3_next       = b3_reg;
        b4_next       = b4_reg;
        last_pos_next = last_pos_reg;
        pos_next      = pos_reg;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;

        // add-3 correction on every bcd digit before the shift
        for (int i = 0; i < DIG_N; i++)
        begin
            adj[i]      = (dig_reg[i] >= 4'd5) ? (dig_reg[i] + 4'd3) : dig_reg[i];
            dig_next[i] = dig_reg[i];
        end

        if (accept)
        begin
            mag_next     = src;
            cnt_next     = '0;
            upper_next   = (in_cmd == CMD_XU);
            use_lit_next = ld_use_lit;
            lit_next     = ld_lit;
            pre_len_next = ld_pre_len;
            pre0_next    = ld_pre0;
            pre1_next    = ld_pre1;
            left_next    = in_left;
            zero_next    = in_zero;
            width_next   = width_sat;
            for (int i = 0; i < DIG_N; i++)
            begin
                if (is_dec)
                begin
                    dig_next[i] = 4'd0;
                end
                else if (in_cmd == CMD_O)
                begin
                    dig_next[i] = {1'b0, src_pad[3*i +: 3]};
                end
                else
                begin
                    dig_next[i] = src_pad[4*i +: 4];
                end
            end
        end

        if (state_reg == ST_CONV)
        begin
            // shift one magnitude bit into the bcd digits
            dig_next[0] = {adj[0][2:0], mag_reg[VALUE_BITS-1]};
            for (int i = 1; i < DIG_N; i++)
            begin
                dig_next[i] = {adj[i][2:0], adj[i-1][3]};
            end
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + BC_W'(1);
        end

        if (state_reg == ST_LEN)
        begin
            dig_len_next = use_lit_reg ? CNT_W'(1) : CNT_W'(nz_len);
        end

        if (state_reg == ST_PLAN)
        begin
            b1_next       = plan_b1;
            b2_next       = plan_b2;
            b3_next       = plan_b3;
            b4_next       = plan_b3 + dig_len_reg;
            last_pos_next = total + pad - CNT_W'(1);
            pos_next      = '0;
        end

        if (emit_go)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            out_last_next  = emit_last;
            pos_next       = pos_reg + CNT_W'(1);
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        dig_reg      <= dig_next;
        upper_reg    <= upper_next;
        use_lit_reg  <= use_lit_next;
        lit_reg      <= lit_next;
        pre_len_reg  <= pre_len_next;
        pre0_reg     <= pre0_next;
        pre1_reg     <= pre1_next;
        left_reg     <= left_next;
        zero_reg     <= zero_next;
        width_reg    <= width_next;
        dig_len_reg  <= dig_len_next;
        b1_reg       <= b1_next;
        b2_reg       <= b2_next;
        b3_reg       <= b3_next;
        b4_reg       <= b4_next;
        last_pos_reg <= last_pos_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule
